// ===== rtl/pss_pkg.sv =====
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types, codes and constants of the priority scheduler.
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int unsigned NumThreads  = 16;
  localparam int unsigned SlotW       = 4;
  localparam int unsigned CountW      = 5;
  localparam int unsigned PrioW       = 6;
  localparam int unsigned TimeW       = 32;
  localparam int unsigned MaxPriority = 63;
  localparam logic [PrioW-1:0] DefaultPriority = 6'd31;
  localparam logic [7:0]       SliceReset      = 8'd4;

  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_CREATE = 3'd1,
    REQ_SLEEP = 3'd2,
    REQ_YIELD = 3'd3,
    REQ_SETPRI = 3'd4,
    REQ_BLOCK = 3'd5,
    REQ_UNBLOCK = 3'd6,
    REQ_EXIT  = 3'd7
  } req_e;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_BLOCKED = 2'd3
  } slot_st_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BUSY    = 2'd1,
    STAT_IDLE    = 2'd2,
    STAT_NOTBLK  = 2'd3
  } status_e;

  // Compare unit operands and result.
  typedef struct packed {
    logic [TimeW-1:0] a;
    logic [TimeW-1:0] b;
  } cmp_req_t;

  typedef struct packed {
    logic le;
    logic lt;
  } cmp_rsp_t;

endpackage

// ===== rtl/pss_cmp.sv =====
// ----------------------------------------------------------------------------
// pss_cmp
// Shared unsigned magnitude comparator used by every queue walk.
// ----------------------------------------------------------------------------
module pss_cmp (
  input  pss_pkg::cmp_req_t req_i,
  output pss_pkg::cmp_rsp_t rsp_o
);

  // Compare both operands once, report both relations.
  assign rsp_o.lt = req_i.a < req_i.b;
  assign rsp_o.le = req_i.a <= req_i.b;

endmodule

// ===== rtl/priority_scheduler_with_sleep_queue.sv =====
// ----------------------------------------------------------------------------
// priority_scheduler_with_sleep_queue
// Thread scheduler with a priority ready queue and a wake-time sleep queue.
// ----------------------------------------------------------------------------
// Usage:
//   A request enters on req_valid_i when req_stall_o is low. The block then
//   stalls until it has produced one result on rsp_valid_o; that result is
//   held while rsp_stall_i is high and the next request waits meanwhile.
//   The time slice register is written on cfg_valid_i / cfg_ready_o.
// Queue walks:
//   Every queue insert or wake walks the queue one entry a cycle through one
//   shared comparator, shifting entries one a cycle. A request that only
//   returns a status touches no queue; the others take longer the more
//   queue entries they touch, most of all a tick that wakes all 16 sleepers.
// Reset:
//   Slot 0 runs with priority 31, all other slots are free, both queues are
//   empty and the time slice is 4. No clearing pass is needed.
// ----------------------------------------------------------------------------
module priority_scheduler_with_sleep_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_stall_o,
  input  logic [2:0]  req_type_i,
  input  logic [3:0]  thread_slot_i,
  input  logic [5:0]  priority_req_i,
  input  logic [31:0] time_value_i,
  output logic        rsp_valid_o,
  input  logic        rsp_stall_i,
  output logic [3:0]  running_slot_o,
  output logic        running_idle_o,
  output logic        switched_o,
  output logic [4:0]  woken_count_o,
  output logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_time_slice_i
);

  localparam int unsigned SW = pss_pkg::SlotW;
  localparam int unsigned CW = pss_pkg::CountW;
  localparam int unsigned TW = pss_pkg::TimeW;
  localparam int unsigned NT = pss_pkg::NumThreads;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_DECODE = 11'b00000000010,
    S_WAKE   = 11'b00000000100,  // test sleep head
    S_WSHIFT = 11'b00000001000,  // pop sleep head
    S_SLICE  = 11'b00000010000,
    S_RSCAN  = 11'b00000100000,  // find insert position in ready queue
    S_RSHIFT = 11'b00001000000,  // open a hole, then write
    S_SSCAN  = 11'b00010000000,
    S_SSHIFT = 11'b00100000000,
    S_DISP   = 11'b01000000000,  // pop ready head
    S_DONE   = 11'b10000000000
  } state_e;

  // What to do after a ready insert finishes.
  typedef enum logic [3:0] {
    AFT_WAKE  = 4'b0001,
    AFT_DISP  = 4'b0010,
    AFT_DONE  = 4'b0100,
    AFT_YIELD = 4'b1000   // requeue the running thread, then dispatch
  } after_e;

  state_e state_q;
  after_e after_q;

  logic [7:0]    slice_len_q;
  logic [1:0]    st_q   [NT];
  logic [5:0]    prio_q [NT];
  logic [TW-1:0] wake_q [NT];
  logic [SW-1:0] rdy_q  [NT];
  logic [SW-1:0] slp_q  [NT];
  logic [CW-1:0] rcnt_q, scnt_q;
  logic [SW-1:0] cur_q;
  logic          idle_q;
  logic [7:0]    slice_q;

  logic [2:0]    req_q;
  logic [SW-1:0] slot_q;
  logic [5:0]    pr_q;
  logic [TW-1:0] tv_q;
  logic          bidle_q;
  logic [SW-1:0] bslot_q;
  logic [CW-1:0] woken_q;
  logic [1:0]    stat_q;
  logic [SW-1:0] ins_q;   // slot being inserted
  logic [CW-1:0] pos_q;   // walk index
  logic          out_v_q;

  // Shared compare unit.
  pss_pkg::cmp_req_t cmp_req;
  pss_pkg::cmp_rsp_t cmp_rsp;
  pss_cmp u_cmp (.req_i(cmp_req), .rsp_o(cmp_rsp));

  logic [SW-1:0] pos_ix;
  assign pos_ix = pos_q[SW-1:0];

  always_comb begin
    cmp_req = '0;
    unique case (state_q)
      S_WAKE: begin
        cmp_req.a = wake_q[slp_q[0]];
        cmp_req.b = tv_q;
      end
      S_RSCAN: begin
        // keep walking while queued priority >= new, i.e. new <= queued
        cmp_req.a = {{(TW-6){1'b0}}, prio_q[ins_q]};
        cmp_req.b = {{(TW-6){1'b0}}, prio_q[rdy_q[pos_ix]]};
      end
      S_SSCAN: begin
        cmp_req.a = wake_q[slp_q[pos_ix]];
        cmp_req.b = wake_q[ins_q];
      end
      S_DECODE: begin
        // set-priority: new < ready head
        cmp_req.a = {{(TW-6){1'b0}}, pr_q};
        cmp_req.b = {{(TW-6){1'b0}}, prio_q[rdy_q[0]]};
      end
      default: cmp_req = '0;
    endcase
  end

  logic in_sleep;
  always_comb begin
    in_sleep = 1'b0;
    for (int i = 0; i < NT; i++) begin
      if (CW'(i) < scnt_q && slp_q[i] == slot_q) in_sleep = 1'b1;
    end
  end

  assign req_stall_o = (state_q != S_IDLE) || out_v_q;
  assign cfg_ready_o = 1'b1;
  assign rsp_valid_o = out_v_q;

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      after_q     <= AFT_DONE;
      slice_len_q <= pss_pkg::SliceReset;
      for (int i = 0; i < NT; i++) begin
        st_q[i]   <= pss_pkg::ST_FREE;
        prio_q[i] <= '0;
      end
      st_q[0]   <= pss_pkg::ST_RUNNING;
      prio_q[0] <= pss_pkg::DefaultPriority;
      rcnt_q    <= '0;
      scnt_q    <= '0;
      cur_q     <= '0;
      idle_q    <= 1'b0;
      slice_q   <= '0;
      out_v_q   <= 1'b0;
      pos_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        slice_len_q <= cfg_time_slice_i;
      end
      if (out_v_q && !rsp_stall_i) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_valid_i && !req_stall_o) begin
            req_q   <= req_type_i;
            slot_q  <= thread_slot_i;
            pr_q    <= priority_req_i;
            tv_q    <= time_value_i;
            bidle_q <= idle_q;
            bslot_q <= idle_q ? '0 : cur_q;
            woken_q <= '0;
            stat_q  <= pss_pkg::STAT_OK;
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          unique case (pss_pkg::req_e'(req_q))
            pss_pkg::REQ_TICK: state_q <= S_WAKE;
            pss_pkg::REQ_CREATE: begin
              if (st_q[slot_q] != pss_pkg::ST_FREE) begin
                stat_q  <= pss_pkg::STAT_BUSY;
                state_q <= S_DONE;
              end else begin
                prio_q[slot_q] <= pr_q;
                ins_q   <= slot_q;
                pos_q   <= '0;
                after_q <= (pr_q > (idle_q ? 6'd0 : prio_q[cur_q])) ? AFT_YIELD : AFT_DONE;
                state_q <= S_RSCAN;
              end
            end
            pss_pkg::REQ_SLEEP: begin
              if (idle_q) begin
                stat_q  <= pss_pkg::STAT_IDLE;
                state_q <= S_DONE;
              end else begin
                wake_q[cur_q] <= tv_q;
                ins_q   <= cur_q;
                pos_q   <= '0;
                state_q <= S_SSCAN;
              end
            end
            pss_pkg::REQ_YIELD: begin
              if (idle_q) begin
                state_q <= S_DISP;
              end else begin
                ins_q   <= cur_q;
                pos_q   <= '0;
                after_q <= AFT_DISP;
                state_q <= S_RSCAN;
              end
            end
            pss_pkg::REQ_SETPRI: begin
              if (idle_q) begin
                state_q <= S_DONE;
              end else begin
                prio_q[cur_q] <= pr_q;
                if (rcnt_q != '0 && cmp_rsp.lt) begin
                  ins_q   <= cur_q;
                  pos_q   <= '0;
                  after_q <= AFT_DISP;
                  state_q <= S_RSCAN;
                end else begin
                  state_q <= S_DONE;
                end
              end
            end
            pss_pkg::REQ_UNBLOCK: begin
              if (st_q[slot_q] != pss_pkg::ST_BLOCKED || in_sleep) begin
                stat_q  <= pss_pkg::STAT_NOTBLK;
                state_q <= S_DONE;
              end else begin
                ins_q   <= slot_q;
                pos_q   <= '0;
                after_q <= AFT_DONE;
                state_q <= S_RSCAN;
              end
            end
            default: begin
              // block or exit
              if (idle_q) begin
                stat_q  <= pss_pkg::STAT_IDLE;
                state_q <= S_DONE;
              end else begin
                st_q[cur_q] <= (req_q == pss_pkg::REQ_BLOCK) ?
                               pss_pkg::ST_BLOCKED : pss_pkg::ST_FREE;
                state_q <= S_DISP;
              end
            end
          endcase
        end
        // Wake: test sleep head against current time.
        S_WAKE: begin
          if (scnt_q != '0 && cmp_rsp.le) begin
            ins_q   <= slp_q[0];
            pos_q   <= CW'(1);
            state_q <= S_WSHIFT;
          end else begin
            state_q <= S_SLICE;
          end
        end
        // Pop sleep head one entry a cycle, then insert into ready queue.
        S_WSHIFT: begin
          if (pos_q < scnt_q) begin
            slp_q[pos_ix - SW'(1)] <= slp_q[pos_ix];
            pos_q <= pos_q + CW'(1);
          end else begin
            scnt_q  <= scnt_q - CW'(1);
            woken_q <= woken_q + CW'(1);
            pos_q   <= '0;
            after_q <= AFT_WAKE;
            state_q <= S_RSCAN;
          end
        end
        S_SLICE: begin
          logic [7:0] sc;
          sc = (slice_q != 8'hFF) ? slice_q + 8'd1 : slice_q;
          slice_q <= sc;
          if (sc >= slice_len_q) begin
            if (idle_q) begin
              state_q <= S_DISP;
            end else begin
              ins_q   <= cur_q;
              pos_q   <= '0;
              after_q <= AFT_DISP;
              state_q <= S_RSCAN;
            end
          end else begin
            state_q <= S_DONE;
          end
        end
        // Walk ready queue while queued priority >= new.
        S_RSCAN: begin
          if (pos_q < rcnt_q && cmp_rsp.le) begin
            pos_q <= pos_q + CW'(1);
          end else begin
            // pos_q is insert position; shift from the tail down
            slot_q  <= pos_ix;
            pos_q   <= rcnt_q;
            state_q <= S_RSHIFT;
          end
        end
        S_RSHIFT: begin
          if (pos_q > {1'b0, slot_q}) begin
            rdy_q[pos_ix] <= rdy_q[pos_ix - SW'(1)];
            pos_q <= pos_q - CW'(1);
          end else begin
            rdy_q[slot_q]  <= ins_q;
            st_q[ins_q]    <= pss_pkg::ST_READY;
            rcnt_q         <= rcnt_q + CW'(1);
            pos_q          <= '0;
            unique case (after_q)
              AFT_WAKE: state_q <= S_WAKE;
              AFT_DISP: state_q <= S_DISP;
              AFT_YIELD: begin
                // Requeue the running thread unless idle runs, then dispatch.
                if (idle_q) begin
                  state_q <= S_DISP;
                end else begin
                  ins_q   <= cur_q;
                  after_q <= AFT_DISP;
                  state_q <= S_RSCAN;
                end
              end
              default:  state_q <= S_DONE;
            endcase
          end
        end
        S_SSCAN: begin
          if (pos_q < scnt_q && cmp_rsp.le) begin
            pos_q <= pos_q + CW'(1);
          end else begin
            slot_q  <= pos_ix;
            pos_q   <= scnt_q;
            state_q <= S_SSHIFT;
          end
        end
        S_SSHIFT: begin
          if (pos_q > {1'b0, slot_q}) begin
            slp_q[pos_ix] <= slp_q[pos_ix - SW'(1)];
            pos_q <= pos_q - CW'(1);
          end else begin
            slp_q[slot_q] <= ins_q;
            st_q[ins_q]   <= pss_pkg::ST_BLOCKED;
            scnt_q        <= scnt_q + CW'(1);
            pos_q         <= '0;
            state_q       <= S_DISP;
          end
        end
        // Dispatch: take ready head (or go idle if none), then close the gap one entry a cycle.
        S_DISP: begin
          if (pos_q == '0) begin
            slice_q <= '0;
            if (rcnt_q == '0) begin
              idle_q  <= 1'b1;
              cur_q   <= '0;
              state_q <= S_DONE;
            end else begin
              cur_q   <= rdy_q[0];
              idle_q  <= 1'b0;
              st_q[rdy_q[0]] <= pss_pkg::ST_RUNNING;
              pos_q   <= CW'(1);
            end
          end else if (pos_q < rcnt_q) begin
            rdy_q[pos_ix - SW'(1)] <= rdy_q[pos_ix];
            pos_q <= pos_q + CW'(1);
          end else begin
            rcnt_q  <= rcnt_q - CW'(1);
            pos_q   <= '0;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_v_q) begin
            running_slot_o <= idle_q ? '0 : cur_q;
            running_idle_o <= idle_q;
            switched_o     <= (bidle_q != idle_q) || (bslot_q != (idle_q ? '0 : cur_q));
            woken_count_o  <= woken_q;
            status_o       <= stat_q;
            out_v_q        <= 1'b1;
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/pss_checker.sv =====
// ----------------------------------------------------------------------------
// pss_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module pss_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_stall_o,
  input logic       rsp_valid_o,
  input logic       rsp_stall_i,
  input logic [3:0] running_slot_o,
  input logic       running_idle_o,
  input logic [4:0] woken_count_o,
  input logic [1:0] status_o
);

  // A request is never accepted while a result is pending.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> req_stall_o) else $error("request taken with result pending");

  // A held result stays valid and keeps its running slot.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |=> rsp_valid_o && $stable(running_slot_o))
    else $error("stalled result changed");

  // Idle reports slot zero.
  a_idle_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && running_idle_o |-> running_slot_o == 4'd0)
    else $error("idle with nonzero slot");

  // Only an ok status can carry woken threads.
  a_woken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && woken_count_o != 5'd0 |-> status_o == 2'd0)
    else $error("woken count with error status");

endmodule

bind priority_scheduler_with_sleep_queue pss_checker u_pss_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .req_valid_i(req_valid_i),
  .req_stall_o(req_stall_o), .rsp_valid_o(rsp_valid_o), .rsp_stall_i(rsp_stall_i),
  .running_slot_o(running_slot_o), .running_idle_o(running_idle_o),
  .woken_count_o(woken_count_o), .status_o(status_o)
);

// ===== tb/sv/tb_priority_scheduler_with_sleep_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_scheduler_with_sleep_queue
// Drives scheduler events with random gaps and stalls, predicts the running
// thread, switch flag, wake count and status of every event, and checks them.
// ----------------------------------------------------------------------------
module tb_priority_scheduler_with_sleep_queue;

  localparam int unsigned CycleLimit = 1000000;

  typedef struct packed {
    logic [3:0]       slot;
    logic             idle;
    logic             sw;
    logic [4:0]       woken;
    pss_pkg::status_e status;
  } sched_rsp_t;

  // Scheduler predictor and store of pending answers
  class sched_tracker;
    pss_pkg::slot_st_e st [pss_pkg::NumThreads];
    logic [5:0]        prio [pss_pkg::NumThreads];
    logic [31:0]       wake [pss_pkg::NumThreads];
    int unsigned       ready_q[$];
    int unsigned       sleep_q[$];
    int unsigned       cur;
    bit                idle;
    int unsigned       slice;
    logic [7:0]        slice_len;
    sched_rsp_t        pending[$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       switches;
    int unsigned       woken_total;

    function new();
      foreach (st[i]) begin
        st[i] = pss_pkg::ST_FREE;
        prio[i] = '0;
        wake[i] = '0;
      end
      st[0] = pss_pkg::ST_RUNNING;
      prio[0] = pss_pkg::DefaultPriority;
      slice_len = pss_pkg::SliceReset;
    endfunction

    function void set_slice(logic [7:0] v);
      slice_len = v;
    endfunction

    // Insert behind every entry of equal or higher priority
    function void ready_put(int unsigned s);
      int unsigned pos;
      pos = 0;
      while (pos < ready_q.size() && prio[ready_q[pos]] >= prio[s]) pos++;
      ready_q.insert(pos, s);
      st[s] = pss_pkg::ST_READY;
    endfunction

    function void dispatch();
      slice = 0;
      if (ready_q.size() == 0) begin
        idle = 1;
        cur = 0;
      end else begin
        cur = ready_q.pop_front();
        idle = 0;
        st[cur] = pss_pkg::ST_RUNNING;
      end
    endfunction

    function void yield_cur();
      if (!idle) ready_put(cur);
      dispatch();
    endfunction

    function bit asleep(int unsigned s);
      foreach (sleep_q[i]) if (sleep_q[i] == s) return 1;
      return 0;
    endfunction

    // Pick a slot in the wanted state, or any slot when none is
    function logic [3:0] pick_slot(pss_pkg::slot_st_e want);
      int unsigned hits[$];
      for (int unsigned i = 0; i < pss_pkg::NumThreads; i++)
        if (st[i] == want && !(want == pss_pkg::ST_BLOCKED && asleep(i)))
          hits.push_back(i);
      if (hits.size() == 0) return 4'($urandom);
      return 4'(hits[$urandom_range(0, hits.size() - 1)]);
    endfunction

    function void note_request(pss_pkg::req_e rq, logic [3:0] slot, logic [5:0] pr,
                               logic [31:0] tv);
      bit               was_idle;
      int unsigned      was_slot, woken, s, pos, cur_pr;
      pss_pkg::status_e stat;
      sched_rsp_t       r;
      was_idle = idle;
      was_slot = idle ? 0 : cur;
      woken = 0;
      stat = pss_pkg::STAT_OK;
      case (rq)
        pss_pkg::REQ_TICK: begin
          while (sleep_q.size() > 0 && wake[sleep_q[0]] <= tv) begin
            s = sleep_q.pop_front();
            ready_put(s);
            woken++;
          end
          if (slice < 255) slice++;
          if (slice >= slice_len) yield_cur();
        end
        pss_pkg::REQ_CREATE: begin
          if (st[slot] != pss_pkg::ST_FREE) stat = pss_pkg::STAT_BUSY;
          else begin
            prio[slot] = pr;
            ready_put(slot);
            cur_pr = idle ? 0 : prio[cur];
            if (pr > cur_pr) yield_cur();
          end
        end
        pss_pkg::REQ_SLEEP: begin
          if (idle) stat = pss_pkg::STAT_IDLE;
          else begin
            wake[cur] = tv;
            pos = 0;
            while (pos < sleep_q.size() && wake[sleep_q[pos]] <= tv) pos++;
            sleep_q.insert(pos, cur);
            st[cur] = pss_pkg::ST_BLOCKED;
            dispatch();
          end
        end
        pss_pkg::REQ_YIELD: yield_cur();
        pss_pkg::REQ_SETPRI: begin
          if (!idle) begin
            prio[cur] = pr;
            if (ready_q.size() > 0 && pr < prio[ready_q[0]]) yield_cur();
          end
        end
        pss_pkg::REQ_BLOCK: begin
          if (idle) stat = pss_pkg::STAT_IDLE;
          else begin
            st[cur] = pss_pkg::ST_BLOCKED;
            dispatch();
          end
        end
        pss_pkg::REQ_UNBLOCK: begin
          if (st[slot] != pss_pkg::ST_BLOCKED || asleep(slot)) stat = pss_pkg::STAT_NOTBLK;
          else ready_put(slot);
        end
        default: begin
          if (idle) stat = pss_pkg::STAT_IDLE;
          else begin
            st[cur] = pss_pkg::ST_FREE;
            dispatch();
          end
        end
      endcase
      r.slot = idle ? 4'd0 : 4'(cur);
      r.idle = idle;
      r.sw = (was_idle != idle) || (was_slot != (idle ? 0 : cur));
      r.woken = 5'(woken);
      r.status = stat;
      pending.push_back(r);
    endfunction

    function void report(string name, int unsigned e, int unsigned a);
      if (e != a) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(sched_rsp_t act);
      sched_rsp_t e;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing pending, actual %p", $time, act);
        errors++;
        return;
      end
      e = pending.pop_front();
      report("running_slot", e.slot, act.slot);
      report("running_idle", e.idle, act.idle);
      report("switched", e.sw, act.sw);
      report("woken_count", e.woken, act.woken);
      report("status", e.status, act.status);
      checked++;
      switches += e.sw;
      woken_total += e.woken;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [2:0]  req_type = '0;
  logic [3:0]  thread_slot = '0;
  logic [5:0]  priority_req = '0;
  logic [31:0] time_value = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [3:0]  running_slot;
  logic        running_idle;
  logic        switched;
  logic [4:0]  woken_count;
  logic [1:0]  status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_time_slice = '0;

  sched_tracker sb = new();
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  hold_left = 0;
  int unsigned  cycles = 0;
  logic [31:0]  now = 32'd100;

  priority_scheduler_with_sleep_queue dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (req_valid),
    .req_stall_o      (req_stall),
    .req_type_i       (req_type),
    .thread_slot_i    (thread_slot),
    .priority_req_i   (priority_req),
    .time_value_i     (time_value),
    .rsp_valid_o      (rsp_valid),
    .rsp_stall_i      (rsp_stall),
    .running_slot_o   (running_slot),
    .running_idle_o   (running_idle),
    .switched_o       (switched),
    .woken_count_o    (woken_count),
    .status_o         (status),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_time_slice_i (cfg_time_slice)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Collect results and drive the receiver stall
  initial begin
    sched_rsp_t act;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_valid && !rsp_stall) begin
        act.slot = running_slot;
        act.idle = running_idle;
        act.sw = switched;
        act.woken = woken_count;
        act.status = pss_pkg::status_e'(status);
        sb.check_result(act);
      end
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Offer one request, idling at random first; valid stays high into the next
  task automatic send(pss_pkg::req_e rq, logic [3:0] slot, logic [5:0] pr,
                      logic [31:0] tv);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk_i);
    end
    req_valid <= 1'b1;
    req_type <= rq;
    thread_slot <= slot;
    priority_req <= pr;
    time_value <= tv;
    do @(posedge clk_i); while (req_stall !== 1'b0);
    sb.note_request(rq, slot, pr, tv);
  endtask

  // Let every pending answer drain, then settle
  task automatic drain();
    req_valid <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_slice(logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_time_slice <= v;
    do @(posedge clk_i); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.set_slice(v);
  endtask

  // Random event, mostly aimed at slots in a useful state
  task automatic send_random();
    int unsigned roll;
    logic [3:0]  slot;
    logic [31:0] tv;
    roll = $urandom_range(0, 99);
    slot = 4'($urandom);
    tv = $urandom;
    if (roll < 30) begin
      now += $urandom_range(0, 6);
      if ($urandom_range(0, 19) == 0) now = $urandom;
      if ($urandom_range(0, 19) != 0) tv = now;
      send(pss_pkg::REQ_TICK, slot, 6'($urandom), tv);
    end else if (roll < 45) begin
      if ($urandom_range(0, 4) != 0) slot = sb.pick_slot(pss_pkg::ST_FREE);
      send(pss_pkg::REQ_CREATE, slot, 6'($urandom), tv);
    end else if (roll < 55) begin
      if ($urandom_range(0, 29) != 0) tv = now + $urandom_range(0, 15);
      send(pss_pkg::REQ_SLEEP, slot, 6'($urandom), tv);
    end else if (roll < 63) begin
      send(pss_pkg::REQ_YIELD, slot, 6'($urandom), tv);
    end else if (roll < 71) begin
      send(pss_pkg::REQ_SETPRI, slot, 6'($urandom), tv);
    end else if (roll < 78) begin
      send(pss_pkg::REQ_BLOCK, slot, 6'($urandom), tv);
    end else if (roll < 92) begin
      if ($urandom_range(0, 4) != 0) slot = sb.pick_slot(pss_pkg::ST_BLOCKED);
      send(pss_pkg::REQ_UNBLOCK, slot, 6'($urandom), tv);
    end else begin
      send(pss_pkg::REQ_EXIT, slot, 6'($urandom), tv);
    end
  endtask

  task automatic run_phase(logic [7:0] slice_v, int unsigned s_pct, int unsigned r_pct,
                           int unsigned n, bit hold);
    drain();
    write_slice(slice_v);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int unsigned i = 0; i < n; i++) begin
      // Hold off the receiver while requests keep coming
      if (hold && i == n / 2) hold_left = 400;
      send_random();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: busy slot, preemption, priority drop, wake, idle requests
    send(pss_pkg::REQ_TICK, 4'd0, 6'd0, 32'd0);
    send(pss_pkg::REQ_CREATE, 4'd0, 6'd5, 32'd0);
    send(pss_pkg::REQ_CREATE, 4'd15, 6'd63, 32'd0);
    send(pss_pkg::REQ_CREATE, 4'd3, 6'd0, 32'd0);
    send(pss_pkg::REQ_SETPRI, 4'd0, 6'd0, 32'd0);
    send(pss_pkg::REQ_SLEEP, 4'd0, 6'd0, 32'hFFFF_FFFF);
    send(pss_pkg::REQ_UNBLOCK, 4'd15, 6'd0, 32'd0);
    send(pss_pkg::REQ_SLEEP, 4'd0, 6'd0, 32'd10);
    send(pss_pkg::REQ_BLOCK, 4'd0, 6'd63, 32'd0);
    send(pss_pkg::REQ_UNBLOCK, 4'd3, 6'd0, 32'd0);
    send(pss_pkg::REQ_UNBLOCK, 4'd9, 6'd0, 32'd0);
    send(pss_pkg::REQ_TICK, 4'd0, 6'd0, 32'd10);
    send(pss_pkg::REQ_EXIT, 4'd0, 6'd0, 32'd0);
    send(pss_pkg::REQ_EXIT, 4'd0, 6'd0, 32'd0);
    send(pss_pkg::REQ_EXIT, 4'd0, 6'd0, 32'd0);
    send(pss_pkg::REQ_EXIT, 4'd0, 6'd0, 32'd0);
    send(pss_pkg::REQ_SLEEP, 4'd0, 6'd0, 32'd0);
    send(pss_pkg::REQ_BLOCK, 4'd0, 6'd0, 32'd0);
    send(pss_pkg::REQ_SETPRI, 4'd0, 6'd20, 32'd0);
    send(pss_pkg::REQ_YIELD, 4'd0, 6'd0, 32'd0);
    send(pss_pkg::REQ_TICK, 4'd0, 6'd0, 32'hFFFF_FFFF);
    send(pss_pkg::REQ_CREATE, 4'd7, 6'd1, 32'd0);
    send(pss_pkg::REQ_TICK, 4'd0, 6'd0, 32'd20);

    run_phase(8'd1, 31, 54, 110, 0);
    run_phase(8'd255, 54, 31, 110, 0);
    run_phase(8'd0, 0, 0, 110, 1);
    run_phase(8'd7, 0, 0, 110, 0);

    drain();
    $display("Checked %0d events with %0d switches and %0d wakeups",
             sb.checked, sb.switches, sb.woken_total);
    $display("Time slices 4, 1, 255, 0 and 7 under idle, stall and hold-off patterns");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
